// ===== rtl/fmair_pkg.sv =====
// Shared types and constants for the first modular affine in range block.
package fmair_pkg;

    localparam int unsigned VAL_W  = 31;  // residues, moduli, multipliers
    localparam int unsigned NUM_W  = 64;  // divider dividend and quotient
    localparam int unsigned X_W    = 63;  // internal answer width
    localparam int unsigned ANS_W  = 62;  // answer and register width
    localparam int unsigned BND_W  = 48;  // range bounds
    localparam int unsigned DIF_W  = 49;  // shifted bounds and range width
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 64;

    // Register index codes, taken from paddr[3].
    localparam logic REG_NOSOL = 1'b0;

    localparam logic [ANS_W-1:0] NOSOL_RESET = 62'd4000000000000000000;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [VAL_W-1:0] rem;
    } t_div_rsp;

endpackage

// ===== rtl/fmair_div.sv =====
// Shared restoring divider: one quotient bit per cycle, 32 or 64 steps.
module fmair_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fmair_pkg::t_div_req i_req,
    output fmair_pkg::t_div_rsp o_rsp
);
    import fmair_pkg::*;

    logic [6:0]       r_cnt;
    logic             r_run;
    logic             r_done;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_den;
    logic [NUM_W-1:0] r_dq;

    logic [VAL_W:0]   shift;
    logic [VAL_W:0]   diff;
    logic             ge;

    assign shift = {r_rem, r_dq[NUM_W-1]};
    assign diff  = shift - {1'b0, r_den};
    assign ge    = shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= (i_req.num[NUM_W-1:32] == '0) ? 7'd32 : 7'd64;
            end else if (r_run) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Short dividends skip the upper half of the shift.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            if (i_req.num[NUM_W-1:32] == '0) begin
                r_dq <= {i_req.num[31:0], 32'd0};
            end else begin
                r_dq <= i_req.num;
            end
        end else if (r_run) begin
            r_rem <= ge ? diff[VAL_W-1:0] : shift[VAL_W-1:0];
            r_dq  <= {r_dq[NUM_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dq;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/first_modular_affine_in_range_top.sv =====
// Top level: least x with (a*x+b) mod m in [l, r], sequenced over a shared divider.
//
//  channel   signals                                   direction  handshake
//  request   i_mult_a i_offset_b i_range_low/high      in         start & !busy
//            i_modulus
//  result    o_found o_first_x                         out        o_valid, one cycle
//  config    psel penable pwrite paddr pwdata prdata   in/out     APB, pready tied high
//
//  One word in flight; busy stays high from accept until the cycle o_valid pulses.
//  Trivial ranges answer straight from the range check; otherwise the steps run the
//  shared serial divider, so the run time is set by the number of Euclid rounds
//  times divider passes.
//  Synchronous active-low reset; no memory and no clearing pass. The receiver cannot stall.
module first_modular_affine_in_range_top #(
    parameter int MOD_BITS = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [fmair_pkg::VAL_W-1:0]           i_mult_a,
    input  logic [fmair_pkg::VAL_W-1:0]           i_offset_b,
    input  logic signed [fmair_pkg::BND_W-1:0]    i_range_low,
    input  logic signed [fmair_pkg::BND_W-1:0]    i_range_high,
    input  logic [fmair_pkg::VAL_W-1:0]           i_modulus,
    output logic                                  o_valid,
    output logic                                  o_found,
    output logic [fmair_pkg::ANS_W-1:0]           o_first_x,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fmair_pkg::PADDR_W-1:0]         paddr,
    input  logic [fmair_pkg::PDATA_W-1:0]         pwdata,
    output logic [fmair_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);
    import fmair_pkg::*;

    localparam logic [VAL_W-1:0] MOD_MASK = VAL_W'((64'd1 << MOD_BITS) - 64'd1);

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_LMOD, S_RMOD, S_GCD, S_GCD2, S_AG, S_MG, S_MGD,
        S_INV, S_INV2, S_INV3, S_INV4, S_AINV, S_PSTART, S_PR, S_PL, S_PB,
        S_PB2, S_LOOP, S_L1, S_L2, S_L3, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
        S_E7, S_ST1, S_ST2, S_PEND, S_DWAIT
    } t_state;

    t_div_req div_req;
    t_div_rsp div_rsp;

    fmair_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // control and registered outputs
    t_state           r_state, n_state;
    logic             r_valid, n_valid;
    logic             r_found, n_found;
    logic [ANS_W-1:0] r_x, n_x;
    logic [ANS_W-1:0] r_nosol;

    // datapath
    t_state           r_ret, n_ret, r_sret, n_sret;
    logic [VAL_W-1:0] r_a, n_a, r_b, n_b, r_m, n_m;
    logic [BND_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [VAL_W-1:0] r_lr, n_lr, r_rr, n_rr, r_gx, n_gx, r_gy, n_gy, r_g, n_g;
    logic [VAL_W-1:0] r_ag, n_ag, r_mg, n_mg, r_ai, n_ai, r_ainv, n_ainv;
    logic [VAL_W-1:0] r_ia, n_ia, r_ib, n_ib, r_ix, n_ix, r_iy, n_iy;
    logic [VAL_W-1:0] r_irem, n_irem, r_pl, n_pl, r_pr, n_pr, r_rq, n_rq;
    logic [VAL_W-1:0] r_k, n_k, r_b0, n_b0, r_ca, n_ca, r_cb, n_cb, r_cm, n_cm;
    logic [VAL_W-1:0] r_r2, n_r2, r_b1, n_b1, r_m1, n_m1, r_a1, n_a1;
    logic [VAL_W-1:0] r_s, n_s, r_d, n_d;
    logic [31:0]      r_t, n_t;
    logic [X_W-1:0]   r_px, n_px, r_x1, n_x1;
    logic             r_pok, n_pok, r_ok1, n_ok1, r_part, n_part, r_single, n_single;
    logic [NUM_W-1:0] r_prod, n_prod;

    // helpers
    logic [DIF_W-1:0] dif, lb, rb, lb_mag, rb_mag;
    logic [VAL_W-1:0] fix_l, fix_r, inv_newx, l2_b1, m1_new, lq, d_new;
    logic [31:0]      inv_tmp, l2_tmp, e4_diff, e5_num, pl_num;
    logic [32:0]      st_u, st_u1, st_u2;
    logic             triv_ok, take2;
    logic [31:0]      mul_x, mul_y;
    logic [NUM_W-1:0] mul_p;

    assign dif    = {r_hi[BND_W-1], r_hi} - {r_lo[BND_W-1], r_lo};
    assign lb     = {r_lo[BND_W-1], r_lo} - {18'd0, r_b};
    assign rb     = {r_hi[BND_W-1], r_hi} - {18'd0, r_b};
    assign lb_mag = lb[DIF_W-1] ? (49'd0 - lb) : lb;
    assign rb_mag = rb[DIF_W-1] ? (49'd0 - rb) : rb;
    assign fix_l  = (lb[DIF_W-1] && div_rsp.rem != '0) ? r_m - div_rsp.rem : div_rsp.rem;
    assign fix_r  = (rb[DIF_W-1] && div_rsp.rem != '0) ? r_m - div_rsp.rem : div_rsp.rem;
    assign triv_ok = (r_lr > r_rr) || (r_lr == '0);

    assign inv_tmp  = {1'b0, r_ix} + ((r_ix >= div_rsp.rem) ? 32'd0 : {1'b0, r_mg})
                      - {1'b0, div_rsp.rem};
    assign inv_newx = inv_tmp[VAL_W-1:0];
    assign pl_num   = {1'b0, r_pl} + {1'b0, r_g} - 32'd1;
    assign lq       = div_rsp.quo[VAL_W-1:0];
    assign m1_new   = r_cm - r_ca;

    assign l2_tmp = {1'b0, div_rsp.rem} + ((div_rsp.rem >= r_r2) ? 32'd0 : {1'b0, r_ca})
                    - {1'b0, r_r2};
    assign l2_b1  = l2_tmp[VAL_W-1:0];

    assign e4_diff = {1'b0, r_s} - {1'b0, div_rsp.rem};
    assign d_new   = (e4_diff[31] || e4_diff == '0) ? 31'd1 : e4_diff[VAL_W-1:0];
    assign e5_num  = {1'b0, r_s} - {1'b0, r_k} + {1'b0, r_d} - 32'd1;

    // t - b0 + m0 stays below three times m0: two conditional subtracts reduce it
    assign st_u  = {1'b0, r_t} + {2'b0, r_mg} - {2'b0, r_b0};
    assign st_u1 = (st_u >= {2'b0, r_mg}) ? st_u - {2'b0, r_mg} : st_u;
    assign st_u2 = (st_u1 >= {2'b0, r_mg}) ? st_u1 - {2'b0, r_mg} : st_u1;

    assign take2 = r_pok && (!r_ok1 || r_px < r_x1);

    assign mul_p = mul_x * mul_y;

    always_comb begin
        n_state = r_state;  n_valid = 1'b0;  n_found = r_found;  n_x = r_x;
        n_ret = r_ret;  n_sret = r_sret;
        n_a = r_a;  n_b = r_b;  n_m = r_m;  n_lo = r_lo;  n_hi = r_hi;
        n_lr = r_lr;  n_rr = r_rr;  n_gx = r_gx;  n_gy = r_gy;  n_g = r_g;
        n_ag = r_ag;  n_mg = r_mg;  n_ai = r_ai;  n_ainv = r_ainv;
        n_ia = r_ia;  n_ib = r_ib;  n_ix = r_ix;  n_iy = r_iy;  n_irem = r_irem;
        n_pl = r_pl;  n_pr = r_pr;  n_rq = r_rq;  n_k = r_k;  n_b0 = r_b0;
        n_ca = r_ca;  n_cb = r_cb;  n_cm = r_cm;  n_r2 = r_r2;  n_b1 = r_b1;
        n_m1 = r_m1;  n_a1 = r_a1;  n_s = r_s;  n_d = r_d;  n_t = r_t;
        n_px = r_px;  n_x1 = r_x1;  n_pok = r_pok;  n_ok1 = r_ok1;
        n_part = r_part;  n_single = r_single;  n_prod = r_prod;
        div_req = '0;
        mul_x = '0;
        mul_y = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a     = i_mult_a;
                    n_b     = i_offset_b;
                    n_lo    = i_range_low;
                    n_hi    = i_range_high;
                    n_m     = i_modulus & MOD_MASK;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (dif[DIF_W-1]) begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = 1'b0;    n_x = r_nosol;
                end else if (dif >= {18'd0, r_m}) begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = 1'b1;    n_x = '0;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {15'd0, lb_mag};
                    div_req.den   = r_m;
                    n_ret = S_LMOD;  n_state = S_DWAIT;
                end
            end
            S_LMOD: begin
                n_lr = fix_l;
                div_req.start = 1'b1;
                div_req.num   = {15'd0, rb_mag};
                div_req.den   = r_m;
                n_ret = S_RMOD;  n_state = S_DWAIT;
            end
            S_RMOD: begin
                n_rr = fix_r;
                n_gx = r_a;
                n_gy = r_m;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (r_gy == '0) begin
                    n_g = r_gx;
                    n_state = S_AG;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_gx};
                    div_req.den   = r_gy;
                    n_ret = S_GCD2;  n_state = S_DWAIT;
                end
            end
            S_GCD2: begin
                n_gx = r_gy;
                n_gy = div_rsp.rem;
                n_state = S_GCD;
            end
            S_AG: begin
                // zero multiplier: only x = 0 can hit, and only if b lands in range
                if (r_a == '0) begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = triv_ok; n_x = triv_ok ? '0 : r_nosol;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_a};
                    div_req.den   = r_g;
                    n_ret = S_MG;  n_state = S_DWAIT;
                end
            end
            S_MG: begin
                n_ag = div_rsp.quo[VAL_W-1:0];
                div_req.start = 1'b1;
                div_req.num   = {33'd0, r_m};
                div_req.den   = r_g;
                n_ret = S_MGD;  n_state = S_DWAIT;
            end
            S_MGD: begin
                n_mg = div_rsp.quo[VAL_W-1:0];
                // multiplier a multiple of m behaves like a zero multiplier
                if (div_rsp.quo[VAL_W-1:0] == 31'd1) begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = triv_ok; n_x = triv_ok ? '0 : r_nosol;
                end else begin
                    n_ia = r_ag;
                    n_ib = div_rsp.quo[VAL_W-1:0];
                    n_ix = '0;
                    n_iy = 31'd1;
                    n_state = S_INV;
                end
            end
            S_INV: begin
                if (r_ia == '0) begin
                    n_ai = r_ix;
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_ag};
                    div_req.den   = r_mg;
                    n_ret = S_AINV;  n_state = S_DWAIT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_ib};
                    div_req.den   = r_ia;
                    n_ret = S_INV2;  n_state = S_DWAIT;
                end
            end
            S_INV2: begin
                n_irem = div_rsp.rem;
                mul_x  = div_rsp.quo[31:0];
                mul_y  = {1'b0, r_iy};
                n_prod = mul_p;
                n_state = S_INV3;
            end
            S_INV3: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod;
                div_req.den   = r_mg;
                n_ret = S_INV4;  n_state = S_DWAIT;
            end
            S_INV4: begin
                // coefficients are kept reduced mod m/g
                n_ib = r_ia;
                n_ia = r_irem;
                n_ix = r_iy;
                n_iy = inv_newx;
                n_state = S_INV;
            end
            S_AINV: begin
                n_ainv   = div_rsp.rem;
                n_part   = 1'b0;
                n_single = (r_lr <= r_rr);
                n_pl     = (r_lr <= r_rr) ? r_lr : '0;
                n_pr     = r_rr;
                n_state  = S_PSTART;
            end
            S_PSTART: begin
                div_req.start = 1'b1;
                div_req.num   = {33'd0, r_pr};
                div_req.den   = r_g;
                n_ret = S_PR;  n_state = S_DWAIT;
            end
            S_PR: begin
                n_rq = div_rsp.quo[VAL_W-1:0];
                div_req.start = 1'b1;
                div_req.num   = {32'd0, pl_num};
                div_req.den   = r_g;
                n_ret = S_PL;  n_state = S_DWAIT;
            end
            S_PL: begin
                if (lq > r_rq) begin
                    n_pok = 1'b0;
                    n_px  = '0;
                    n_state = S_PEND;
                end else begin
                    n_k    = r_rq - lq;
                    mul_x  = {1'b0, lq};
                    mul_y  = {1'b0, r_ai};
                    n_prod = mul_p;
                    n_state = S_PB;
                end
            end
            S_PB: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod;
                div_req.den   = r_mg;
                n_ret = S_PB2;  n_state = S_DWAIT;
            end
            S_PB2: begin
                n_cb = div_rsp.rem;
                n_b0 = div_rsp.rem;
                n_ca = r_ai;
                n_cm = r_mg;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_ca == '0) begin
                    n_px  = {32'd0, r_cb};
                    n_pok = 1'b1;
                    n_state = S_PEND;
                end else if ({r_ca, 1'b0} < {1'b0, r_cm}) begin
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_cm};
                    div_req.den   = r_ca;
                    n_ret = S_L1;  n_state = S_DWAIT;
                end else begin
                    n_m1 = m1_new;
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_ca};
                    div_req.den   = m1_new;
                    n_ret = S_E1;  n_state = S_DWAIT;
                end
            end
            S_L1: begin
                n_r2 = div_rsp.rem;
                if (r_cb < r_ca) begin
                    n_b1 = r_cb;
                    n_t  = {1'b0, r_cb};
                    n_sret = S_L3;  n_state = S_ST1;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = {33'd0, r_cb};
                    div_req.den   = r_ca;
                    n_ret = S_L2;  n_state = S_DWAIT;
                end
            end
            S_L2: begin
                n_b1 = l2_b1;
                n_t  = {1'b0, l2_b1};
                n_sret = S_L3;  n_state = S_ST1;
            end
            S_L3: begin
                if (div_rsp.rem > r_k) begin
                    n_px  = {32'd0, r_cb};
                    n_pok = 1'b1;
                    n_state = S_PEND;
                end else begin
                    n_cb = r_b1;
                    n_cm = r_ca;
                    n_ca = (r_r2 == '0) ? '0 : r_ca - r_r2;
                    n_state = S_LOOP;
                end
            end
            S_E1: begin
                n_a1 = div_rsp.rem;
                div_req.start = 1'b1;
                div_req.num   = {33'd0, r_cb};
                div_req.den   = r_m1;
                n_ret = S_E2;  n_state = S_DWAIT;
            end
            S_E2: begin
                n_b1 = div_rsp.rem;
                n_t  = {1'b0, div_rsp.rem};
                n_sret = S_E3;  n_state = S_ST1;
            end
            S_E3: begin
                n_s = div_rsp.rem;
                if (div_rsp.rem > r_k) begin
                    n_t = {1'b0, r_b1} + {1'b0, r_m1};
                    n_sret = S_E4;  n_state = S_ST1;
                end else begin
                    n_ca = r_a1;
                    n_cb = r_b1;
                    n_cm = r_m1;
                    n_state = S_LOOP;
                end
            end
            S_E4: begin
                // step per period; clamp to one when it does not shrink
                n_d = d_new;
                n_state = S_E5;
            end
            S_E5: begin
                div_req.start = 1'b1;
                div_req.num   = {32'd0, e5_num};
                div_req.den   = r_d;
                n_ret = S_E6;  n_state = S_DWAIT;
            end
            S_E6: begin
                mul_x  = {1'b0, r_m1};
                mul_y  = div_rsp.quo[31:0];
                n_prod = mul_p;
                n_state = S_E7;
            end
            S_E7: begin
                n_px  = r_prod[X_W-1:0] + {32'd0, r_b1};
                n_pok = 1'b1;
                n_state = S_PEND;
            end
            S_ST1: begin
                mul_x  = {1'b0, st_u2[VAL_W-1:0]};
                mul_y  = {1'b0, r_ainv};
                n_prod = mul_p;
                n_state = S_ST2;
            end
            S_ST2: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod;
                div_req.den   = r_mg;
                n_ret = r_sret;  n_state = S_DWAIT;
            end
            S_PEND: begin
                if (!r_part && r_single) begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = r_pok;   n_x = r_pok ? r_px[ANS_W-1:0] : r_nosol;
                end else if (!r_part) begin
                    // wrapped range: hold the low part, run the high part
                    n_x1   = r_px;
                    n_ok1  = r_pok;
                    n_pl   = r_lr;
                    n_pr   = r_m - 31'd1;
                    n_part = 1'b1;
                    n_state = S_PSTART;
                end else begin
                    n_state = S_IDLE;  n_valid = 1'b1;
                    n_found = r_ok1 || r_pok;
                    if (take2) begin
                        n_x = r_px[ANS_W-1:0];
                    end else if (r_ok1) begin
                        n_x = r_x1[ANS_W-1:0];
                    end else begin
                        n_x = r_nosol;
                    end
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_x     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_found <= n_found;
            r_x     <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_sret <= n_sret;
        r_a <= n_a;  r_b <= n_b;  r_m <= n_m;  r_lo <= n_lo;  r_hi <= n_hi;
        r_lr <= n_lr;  r_rr <= n_rr;  r_gx <= n_gx;  r_gy <= n_gy;  r_g <= n_g;
        r_ag <= n_ag;  r_mg <= n_mg;  r_ai <= n_ai;  r_ainv <= n_ainv;
        r_ia <= n_ia;  r_ib <= n_ib;  r_ix <= n_ix;  r_iy <= n_iy;  r_irem <= n_irem;
        r_pl <= n_pl;  r_pr <= n_pr;  r_rq <= n_rq;  r_k <= n_k;  r_b0 <= n_b0;
        r_ca <= n_ca;  r_cb <= n_cb;  r_cm <= n_cm;  r_r2 <= n_r2;  r_b1 <= n_b1;
        r_m1 <= n_m1;  r_a1 <= n_a1;  r_s <= n_s;  r_d <= n_d;  r_t <= n_t;
        r_px <= n_px;  r_x1 <= n_x1;  r_pok <= n_pok;  r_ok1 <= n_ok1;
        r_part <= n_part;  r_single <= n_single;  r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nosol <= NOSOL_RESET;
        end else if (psel && penable && pwrite && paddr[3] == REG_NOSOL) begin
            r_nosol <= pwdata[ANS_W-1:0];
        end
    end

    assign prdata    = (paddr[3] == REG_NOSOL) ? {2'b00, r_nosol} : '0;
    assign pready    = 1'b1;
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_found   = r_found;
    assign o_first_x = r_x;

`ifndef SYNTHESIS
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result delivered while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_div_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DWAIT))
        else $error("divider finished outside a wait");
`endif

endmodule
